[src/assert_macros.svh]
// Assertion macros used by the deframer top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

[src/rbd_pkg.sv]
// Package with the types, codes and constants of the response body deframer.
`timescale 1ns / 1ps
package rbd_pkg;

	localparam int unsigned MAX_LINE_DEF = 4096;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_stream;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [1:0] kind;
		logic [2:0] error_code;
	} out_item_t;

	localparam logic [1:0] KIND_BODY = 2'd0;
	localparam logic [1:0] KIND_DONE = 2'd1;
	localparam logic [1:0] KIND_FAIL = 2'd2;

	localparam logic [2:0] ERR_NONE       = 3'd0;
	localparam logic [2:0] ERR_EARLY_END  = 3'd1;
	localparam logic [2:0] ERR_BAD_MODE   = 3'd2;
	localparam logic [2:0] ERR_BAD_CHUNK  = 3'd3;
	localparam logic [2:0] ERR_LINE_LONG  = 3'd4;
	localparam logic [2:0] ERR_NO_CRLF    = 3'd5;
	localparam logic [2:0] ERR_FINAL_LINE = 3'd6;

	typedef enum logic [3:0] {
		PH_START,
		PH_LINE1,
		PH_LINE2,
		PH_RAW,
		PH_EXACT,
		PH_EXACT_END,
		PH_CSIZE,
		PH_CDATA,
		PH_CCR,
		PH_CLF,
		PH_FINAL,
		PH_DONE
	} phase_t;

	typedef struct packed {
		logic ext;
		logic bad;
		logic digit;
		logic neg;
		logic cr;
	} line_flags_t;

	typedef struct packed {
		phase_t      phase;
		line_flags_t flags;
		logic [63:0] acc;
		logic [63:0] remaining;
	} step_state_t;

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;

	localparam logic [63:0] DEC_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;

endpackage

[src/rbd_step.sv]
// Combinational next-state and result logic for one byte of the deframer.
`timescale 1ns / 1ps
module rbd_step #(
	parameter int unsigned MAX_LINE = rbd_pkg::MAX_LINE_DEF
) (
	input  logic                        header_enable,
	input  rbd_pkg::in_item_t           item,
	input  rbd_pkg::step_state_t        cur,
	input  logic [$clog2(MAX_LINE)-1:0] line_count,
	output rbd_pkg::step_state_t        nxt,
	output logic [$clog2(MAX_LINE)-1:0] line_count_next,
	output logic                        res_valid,
	output rbd_pkg::out_item_t          res
);

	localparam int unsigned LCW = $clog2(MAX_LINE);
	localparam logic [LCW-1:0] LineLimit = LCW'(MAX_LINE - 2);

	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end
		return r;
	endfunction

	rbd_pkg::phase_t      ph_eff;
	logic [7:0]           b;
	logic                 eos;
	logic                 is_lf;
	logic                 too_long;
	logic                 is_dec;
	logic [3:0]           dec_d;
	logic [67:0]          dec_sum;
	logic [4:0]           hex_d;
	rbd_pkg::line_flags_t feed_flags;
	logic [63:0]          feed_acc;
	logic                 l2_bad;
	logic                 l2_raw;
	logic                 l2_chunk;
	logic                 l2_zero;
	logic                 cs_bad;
	logic                 final_empty;
	logic                 rem_last;

	assign b        = item.in_byte;
	assign eos      = item.end_of_stream;
	assign ph_eff   = (cur.phase == rbd_pkg::PH_START)
		? (header_enable ? rbd_pkg::PH_LINE1 : rbd_pkg::PH_RAW) : cur.phase;
	assign is_lf    = (b == rbd_pkg::CH_LF);
	assign too_long = (line_count >= LineLimit);
	assign is_dec   = (b >= 8'h30) && (b <= 8'h39);
	assign dec_d    = 4'(b - 8'h30);
	assign dec_sum  = {1'b0, cur.acc, 3'b000} + {3'b000, cur.acc, 1'b0} + {64'd0, dec_d};
	assign hex_d    = hex_decode(b);
	assign rem_last = (cur.remaining == 64'd1);

	// Line-end decisions are taken on the flags and value before the LF.
	assign l2_bad   = cur.flags.bad || !cur.flags.digit ||
		(cur.flags.neg && cur.acc != 64'd0 && cur.acc != 64'd1 && cur.acc != 64'd2);
	assign l2_raw   = cur.flags.neg && (cur.acc == 64'd1);
	assign l2_chunk = cur.flags.neg && (cur.acc == 64'd2);
	assign l2_zero  = (cur.acc == 64'd0);
	assign cs_bad   = cur.flags.bad || !cur.flags.digit;
	assign final_empty = (line_count == '0) ||
		((line_count == LCW'(1)) && cur.flags.cr);

	// Number parsing of a byte that extends the current line. A CR held back
	// from the previous byte is fed first, as it turned out not to end the line.
	always_comb begin
		feed_flags = cur.flags;
		feed_acc   = cur.acc;
		if (feed_flags.cr) begin
			feed_flags.cr = 1'b0;
			if (ph_eff == rbd_pkg::PH_LINE2) begin
				feed_flags.bad = 1'b1;
			end else if (ph_eff == rbd_pkg::PH_CSIZE && !feed_flags.ext) begin
				feed_flags.bad = 1'b1;
			end
		end
		if (b == rbd_pkg::CH_CR) begin
			feed_flags.cr = 1'b1;
		end else if (ph_eff == rbd_pkg::PH_LINE2) begin
			if (!feed_flags.bad) begin
				if (line_count == '0 && (b == rbd_pkg::CH_MINUS || b == rbd_pkg::CH_PLUS)) begin
					if (b == rbd_pkg::CH_MINUS) begin
						feed_flags.neg = 1'b1;
					end
				end else if (is_dec) begin
					if (dec_sum > {4'd0, rbd_pkg::DEC_LIMIT}) begin
						feed_flags.bad = 1'b1;
					end else begin
						feed_acc         = dec_sum[63:0];
						feed_flags.digit = 1'b1;
					end
				end else begin
					feed_flags.bad = 1'b1;
				end
			end
		end else if (ph_eff == rbd_pkg::PH_CSIZE) begin
			if (!feed_flags.ext) begin
				if (b == rbd_pkg::CH_SEMI) begin
					feed_flags.ext = 1'b1;
				end else if (!feed_flags.bad) begin
					if (hex_d[4] && cur.acc[63:60] == 4'd0) begin
						feed_acc         = {cur.acc[59:0], hex_d[3:0]};
						feed_flags.digit = 1'b1;
					end else begin
						feed_flags.bad = 1'b1;
					end
				end
			end
		end
	end

	// Next state.
	always_comb begin
		nxt             = cur;
		nxt.phase       = ph_eff;
		line_count_next = line_count;
		case (ph_eff)
			rbd_pkg::PH_RAW: begin
				if (eos) begin
					nxt.phase = rbd_pkg::PH_DONE;
				end
			end
			rbd_pkg::PH_EXACT_END: begin
				nxt.phase = rbd_pkg::PH_DONE;
			end
			rbd_pkg::PH_EXACT, rbd_pkg::PH_CDATA: begin
				if (eos) begin
					nxt.phase = rbd_pkg::PH_DONE;
				end else begin
					nxt.remaining = cur.remaining - 64'd1;
					if (rem_last) begin
						nxt.phase = (ph_eff == rbd_pkg::PH_EXACT)
							? rbd_pkg::PH_EXACT_END : rbd_pkg::PH_CCR;
					end
				end
			end
			rbd_pkg::PH_CCR: begin
				nxt.phase = (eos || b != rbd_pkg::CH_CR) ? rbd_pkg::PH_DONE : rbd_pkg::PH_CLF;
			end
			rbd_pkg::PH_CLF: begin
				nxt.phase = (eos || b != rbd_pkg::CH_LF) ? rbd_pkg::PH_DONE : rbd_pkg::PH_CSIZE;
			end
			rbd_pkg::PH_LINE1, rbd_pkg::PH_LINE2, rbd_pkg::PH_CSIZE, rbd_pkg::PH_FINAL: begin
				if (eos) begin
					nxt.phase = rbd_pkg::PH_DONE;
				end else if (is_lf) begin
					nxt.flags       = '0;
					nxt.acc         = '0;
					line_count_next = '0;
					if (ph_eff == rbd_pkg::PH_LINE1) begin
						nxt.phase = rbd_pkg::PH_LINE2;
					end else if (ph_eff == rbd_pkg::PH_LINE2) begin
						if (l2_bad) begin
							nxt.phase = rbd_pkg::PH_DONE;
						end else if (l2_raw) begin
							nxt.phase = rbd_pkg::PH_RAW;
						end else if (l2_chunk) begin
							nxt.phase = rbd_pkg::PH_CSIZE;
						end else if (l2_zero) begin
							nxt.phase = rbd_pkg::PH_DONE;
						end else begin
							nxt.remaining = cur.acc;
							nxt.phase     = rbd_pkg::PH_EXACT;
						end
					end else if (ph_eff == rbd_pkg::PH_CSIZE) begin
						if (cs_bad) begin
							nxt.phase = rbd_pkg::PH_DONE;
						end else if (l2_zero) begin
							nxt.phase = rbd_pkg::PH_FINAL;
						end else begin
							nxt.remaining = cur.acc;
							nxt.phase     = rbd_pkg::PH_CDATA;
						end
					end else begin
						nxt.phase = rbd_pkg::PH_DONE;
					end
				end else if (too_long) begin
					nxt.phase = rbd_pkg::PH_DONE;
				end else begin
					nxt.flags       = feed_flags;
					nxt.acc         = feed_acc;
					line_count_next = line_count + LCW'(1);
				end
			end
			default: begin
				nxt.phase = cur.phase;
			end
		endcase
	end

	// Result of the byte, if it causes one.
	always_comb begin
		res_valid = 1'b0;
		res       = '0;
		case (ph_eff)
			rbd_pkg::PH_RAW: begin
				res_valid = 1'b1;
				if (eos) begin
					res.kind = rbd_pkg::KIND_DONE;
				end else begin
					res.out_byte = b;
				end
			end
			rbd_pkg::PH_EXACT_END: begin
				res_valid = 1'b1;
				res.kind  = rbd_pkg::KIND_DONE;
			end
			rbd_pkg::PH_EXACT, rbd_pkg::PH_CDATA: begin
				res_valid = 1'b1;
				if (eos) begin
					res.kind       = rbd_pkg::KIND_FAIL;
					res.error_code = rbd_pkg::ERR_EARLY_END;
				end else begin
					res.out_byte = b;
				end
			end
			rbd_pkg::PH_CCR, rbd_pkg::PH_CLF: begin
				if (eos) begin
					res_valid      = 1'b1;
					res.kind       = rbd_pkg::KIND_FAIL;
					res.error_code = rbd_pkg::ERR_EARLY_END;
				end else if (b != ((ph_eff == rbd_pkg::PH_CCR) ? rbd_pkg::CH_CR
					: rbd_pkg::CH_LF)) begin
					res_valid      = 1'b1;
					res.kind       = rbd_pkg::KIND_FAIL;
					res.error_code = rbd_pkg::ERR_NO_CRLF;
				end
			end
			rbd_pkg::PH_LINE1, rbd_pkg::PH_LINE2, rbd_pkg::PH_CSIZE, rbd_pkg::PH_FINAL: begin
				if (eos) begin
					res_valid      = 1'b1;
					res.kind       = rbd_pkg::KIND_FAIL;
					res.error_code = rbd_pkg::ERR_EARLY_END;
				end else if (is_lf) begin
					if (ph_eff == rbd_pkg::PH_LINE2) begin
						if (l2_bad) begin
							res_valid      = 1'b1;
							res.kind       = rbd_pkg::KIND_FAIL;
							res.error_code = rbd_pkg::ERR_BAD_MODE;
						end else if (!l2_raw && !l2_chunk && l2_zero) begin
							res_valid = 1'b1;
							res.kind  = rbd_pkg::KIND_DONE;
						end
					end else if (ph_eff == rbd_pkg::PH_CSIZE) begin
						if (cs_bad) begin
							res_valid      = 1'b1;
							res.kind       = rbd_pkg::KIND_FAIL;
							res.error_code = rbd_pkg::ERR_BAD_CHUNK;
						end
					end else if (ph_eff == rbd_pkg::PH_FINAL) begin
						res_valid = 1'b1;
						if (final_empty) begin
							res.kind = rbd_pkg::KIND_DONE;
						end else begin
							res.kind       = rbd_pkg::KIND_FAIL;
							res.error_code = rbd_pkg::ERR_FINAL_LINE;
						end
					end
				end else if (too_long) begin
					res_valid      = 1'b1;
					res.kind       = rbd_pkg::KIND_FAIL;
					res.error_code = rbd_pkg::ERR_LINE_LONG;
				end
			end
			default: begin
				res_valid = 1'b0;
			end
		endcase
	end

endmodule

[src/response_body_deframer.sv]
// Top level of the response body deframer: input stage, parse state and result register.
`timescale 1ns / 1ps
// Usage:
// Response bytes enter on the item channel (item_valid / item_ready / item), one per
// transaction; a transaction with end_of_stream set carries no byte and marks the
// peer's close. Results leave on the result channel: body bytes (kind 0), then one
// final transaction that says finished (kind 1) or failed (kind 2, with error_code).
// The one configuration bit, header_enable, is written on the cfg channel, which is
// always ready. It is sampled by the first item after reset: when set, two header
// lines and a decimal body mode are parsed before the body; when clear, all bytes
// are body. Write it only while the block is idle.
// An accepted item waits in the input stage register and is parsed once the result
// slot is free or draining; any result then enters the result register and
// result_valid rises. Throughput: one item per cycle unless the receiver stalls.
// The per-byte parse is one logic pass from input stage to state and result registers.
// When the receiver stalls, the result register holds; the input stage still takes
// one more item, and item_ready falls once that item waits on a full result slot.
// Reset clears the state machine, line counter and valid bits; no clearing pass.
// After the final transaction, all further items are accepted and dropped.
module response_body_deframer #(
	parameter int unsigned MAX_LINE = rbd_pkg::MAX_LINE_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  rbd_pkg::in_item_t  item,
	output logic               result_valid,
	input  logic               result_ready,
	output rbd_pkg::out_item_t result,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_header_enable
);

`include "assert_macros.svh"

	localparam int unsigned LCW = $clog2(MAX_LINE);
	localparam logic [LCW-1:0] LineLimit = LCW'(MAX_LINE - 2);

	// Configuration register.
	logic header_enable_q;

	// Input stage.
	logic              valid_s1;
	rbd_pkg::in_item_t item_s1;

	// Parse state.
	rbd_pkg::step_state_t state_q;
	logic [LCW-1:0]       line_count_q;

	// Result register.
	logic               result_valid_q;
	rbd_pkg::out_item_t result_q;

	// Step outputs.
	rbd_pkg::step_state_t state_next;
	logic [LCW-1:0]       line_count_next;
	logic                 res_valid;
	rbd_pkg::out_item_t   res;

	// The staged item is parsed when the result slot is free or being drained.
	logic proc;

	assign proc         = valid_s1 && (!result_valid_q || result_ready);
	assign item_ready   = !valid_s1 || proc;
	assign cfg_ready    = 1'b1;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_enable_q <= 1'b0;
		end else if (cfg_valid) begin
			header_enable_q <= cfg_header_enable;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

	rbd_step #(
		.MAX_LINE(MAX_LINE)
	) u_step (
		.header_enable  (header_enable_q),
		.item           (item_s1),
		.cur            (state_q),
		.line_count     (line_count_q),
		.nxt            (state_next),
		.line_count_next(line_count_next),
		.res_valid      (res_valid),
		.res            (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase     <= rbd_pkg::PH_START;
			state_q.flags     <= '0;
			state_q.acc       <= '0;
			state_q.remaining <= '0;
			line_count_q      <= '0;
		end else if (proc) begin
			state_q      <= state_next;
			line_count_q <= line_count_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (proc) begin
			result_valid_q <= res_valid;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && res_valid) begin
			result_q <= res;
		end
	end

	// A finishing or failing result is only produced together with the move to done.
	`ASSERT_IMPLY(a_term_sets_done, result_valid_q && (result_q.kind != rbd_pkg::KIND_BODY), state_q.phase == rbd_pkg::PH_DONE, "terminal result without done phase")
	// Once done, the parser never leaves that phase before reset.
	`ASSERT_NEXT(a_done_sticky, state_q.phase == rbd_pkg::PH_DONE, state_q.phase == rbd_pkg::PH_DONE, "parser left done phase")
	// The line counter stops at the line length limit.
	`ASSERT_ALWAYS(a_line_bound, line_count_q <= LineLimit, "line counter beyond limit")
	// Only failures carry an error code.
	`ASSERT_IMPLY(a_err_only_fail, result_valid_q && (result_q.kind != rbd_pkg::KIND_FAIL), result_q.error_code == rbd_pkg::ERR_NONE, "error code on non-failure result")

endmodule
